// ===== sv/compacting_vector_store_macros.svh =====
// ----------------------------------------------------------------------------
// compacting_vector_store assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_VECTOR_STORE_MACROS_SVH
`define COMPACTING_VECTOR_STORE_MACROS_SVH

// same-cycle implication
`define CVS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_pkg
// Sizes, request and status codes, and cell control type of the vector store.
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int WORD_W      = 32;
	localparam int POS_W       = 8;
	localparam int COUNT_W     = 5;
	localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CMP_W       = (USED_W > POS_W) ? USED_W : POS_W;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_GET    = 2'd1,
		REQ_SET    = 2'd2,
		REQ_DELETE = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef struct packed {
		logic load_word;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== sv/cvs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvs_cell
// One slot of the store: loads a new word or takes its upper neighbor's word.
// ----------------------------------------------------------------------------
module cvs_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cvs_pkg::cell_ctl_t        ctl,
	input  logic [cvs_pkg::WORD_W-1:0] word_in,
	input  logic [cvs_pkg::WORD_W-1:0] next_word,
	output logic [cvs_pkg::WORD_W-1:0] slot
);

	logic [cvs_pkg::WORD_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.shift) begin
			slot_q <= next_word;
		end else if (ctl.load_word) begin
			slot_q <= word_in;
		end
	end

	assign slot = slot_q;

endmodule

// ===== sv/compacting_vector_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_vector_store
// Bounded ordered list of words with append, get, set and shift-delete.
// ----------------------------------------------------------------------------
// Request channel (in_valid/in_ready): req_type, position, word_in.
// Result channel (out_valid/out_ready): word_out, status, count.
// Each request transaction yields exactly one result transaction.
// Latency: the result is registered and valid the cycle after acceptance.
// Throughput: one request per cycle while the receiver keeps up; every slot
// is its own cell, and a delete moves all later words down one cell at once.
// Get reads the addressed cell through a read mux into the result register.
// in_ready is high while the result register is empty or being drained, so
// a stalled receiver holds the result and blocks new requests only then.
// Reset clears all slots and the internal entry count to zero; no result is
// pending after reset. Freed slots are zero again after a delete.
// ----------------------------------------------------------------------------
`include "compacting_vector_store_macros.svh"

module compacting_vector_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [cvs_pkg::POS_W-1:0]   position,
	input  logic [cvs_pkg::WORD_W-1:0]  word_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cvs_pkg::WORD_W-1:0]  word_out,
	output logic [1:0]                  status,
	output logic [cvs_pkg::COUNT_W-1:0] count
);

	logic [cvs_pkg::WORD_W-1:0] slot [cvs_pkg::MAX_ENTRIES];
	cvs_pkg::cell_ctl_t         ctl  [cvs_pkg::MAX_ENTRIES];

	logic [cvs_pkg::USED_W-1:0]  used_q;
	logic [cvs_pkg::USED_W-1:0]  used_next;
	logic                        out_valid_q;
	logic [cvs_pkg::WORD_W-1:0]  word_out_q;
	cvs_pkg::status_e_t          status_q;
	logic [cvs_pkg::COUNT_W-1:0] count_q;

	logic                       accept;
	logic                       full;
	logic                       in_range;
	logic                       do_append;
	logic                       do_set;
	logic                       do_delete;
	logic [cvs_pkg::WORD_W-1:0] rd_word;
	cvs_pkg::status_e_t         st;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign full     = used_q >= cvs_pkg::USED_W'(cvs_pkg::MAX_ENTRIES);
	assign in_range = cvs_pkg::CMP_W'(position) < cvs_pkg::CMP_W'(used_q);

	always_comb begin
		do_append = 1'b0;
		do_set    = 1'b0;
		do_delete = 1'b0;
		rd_word   = '0;
		st        = cvs_pkg::ST_OK;
		used_next = used_q;
		unique case (req_type)
			cvs_pkg::REQ_APPEND: begin
				if (full) begin
					st = cvs_pkg::ST_FULL;
				end else begin
					do_append = 1'b1;
					used_next = used_q + 1'b1;
				end
			end
			cvs_pkg::REQ_GET: begin
				if (!in_range) st = cvs_pkg::ST_RANGE;
				else rd_word = slot[position[cvs_pkg::IDX_W-1:0]];
			end
			cvs_pkg::REQ_SET: begin
				if (!in_range) st = cvs_pkg::ST_RANGE;
				else do_set = 1'b1;
			end
			cvs_pkg::REQ_DELETE: begin
				if (!in_range) begin
					st = cvs_pkg::ST_RANGE;
				end else begin
					do_delete = 1'b1;
					used_next = used_q - 1'b1;
				end
			end
			default: st = cvs_pkg::ST_OK;
		endcase
	end

	for (genvar i = 0; i < cvs_pkg::MAX_ENTRIES; i++) begin : g_cell
		logic [cvs_pkg::WORD_W-1:0] next_word;

		if (i == cvs_pkg::MAX_ENTRIES - 1) begin : g_last
			assign next_word = '0;
		end else begin : g_mid
			assign next_word = slot[i+1];
		end

		assign ctl[i].load_word = accept && (
			(do_append && (cvs_pkg::USED_W'(i) == used_q)) ||
			(do_set && (cvs_pkg::CMP_W'(i) == cvs_pkg::CMP_W'(position))));
		assign ctl[i].shift = accept && do_delete &&
			(cvs_pkg::CMP_W'(i) >= cvs_pkg::CMP_W'(position));

		cvs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.word_in   (word_in),
			.next_word (next_word),
			.slot      (slot[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				used_q      <= used_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_out_q <= rd_word;
			status_q   <= st;
			count_q    <= cvs_pkg::COUNT_W'(used_next);
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = word_out_q;
	assign status    = status_q;
	assign count     = count_q;

	`CVS_ASSERT_IMPL(a_used_bound, 1'b1, used_q <= cvs_pkg::USED_W'(cvs_pkg::MAX_ENTRIES), "count above capacity")
	`CVS_ASSERT_NEXT(a_append_grows, accept && do_append, used_q == $past(used_q) + 1'b1, "append did not grow count")
	`CVS_ASSERT_IMPL(a_err_word_zero, out_valid && (status != cvs_pkg::ST_OK), word_out == '0, "error result carries data")
	`CVS_ASSERT_NEXT(a_delete_tail_zero, accept && do_delete, slot[cvs_pkg::MAX_ENTRIES-1] == '0, "tail slot not cleared on delete")

endmodule
